### sv/bbe_pkg.sv
`default_nettype none

package bbe_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;

   localparam int FW_W     = 11;
   localparam int FH_W     = 13;
   localparam int FW_RESET = 640;
   localparam int FH_RESET = 480;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
   localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int OROW_W = $clog2(MAX_HEIGHT);

   localparam int WIN_SIDE = 3;
   localparam int WIN_TAPS = WIN_SIDE * WIN_SIDE;
   localparam int SUM_W    = $clog2(WIN_TAPS * ((1 << CHAN_W) - 1) + 1);
   localparam int CNT_W    = $clog2(WIN_TAPS + 1);

   localparam int RECIP_SHIFT = 15;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int REG_SEL_BIT = 2;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic [WCNT_W-1:0] width;
      logic [HCNT_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic [SUM_W-1:0]   red;
      logic [SUM_W-1:0]   green;
      logic [SUM_W-1:0]   blue;
      logic [RECIP_W-1:0] recip;
      logic               frame_end;
   } sum_type;

   // ceil(2^RECIP_SHIFT / n), exact floor division for window sums
   function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         CNT_W'(1): r = RECIP_W'(32768);
         CNT_W'(2): r = RECIP_W'(16384);
         CNT_W'(3): r = RECIP_W'(10923);
         CNT_W'(4): r = RECIP_W'(8192);
         CNT_W'(5): r = RECIP_W'(6554);
         CNT_W'(6): r = RECIP_W'(5462);
         CNT_W'(7): r = RECIP_W'(4682);
         CNT_W'(8): r = RECIP_W'(4096);
         CNT_W'(9): r = RECIP_W'(3641);
         default:   r = RECIP_W'(32768);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/bbe_ifs.sv
`default_nettype none

interface bbe_req_if;
   import bbe_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   logic              flush;

   modport source (output valid, red_in, green_in, blue_in, flush, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

interface bbe_rsp_if;
   import bbe_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

### sv/box_blur_3x3_edge_average.sv
`default_nettype none

// channel   dir  handshake                 payload
// req_bus   in   valid/ready               red_in green_in blue_in flush
// rsp_bus   out  valid/ready               red_out green_out blue_out frame_end
// csr       in   psel/penable/pwrite       paddr pwdata -> prdata, pready high
//
// an item with a result passes accept and line store read, window shift and store
// write-back, window sum, and reciprocal multiply into the output register; an item
// without a result ends after the write-back, a flush in the pixel phase after accept
// the output register frees the divide step once its transaction is taken
// synchronous reset clears counters, window and control; line stores are not cleared

module box_blur_3x3_edge_average (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bbe_req_if.sink                              req_bus,
   bbe_rsp_if.source                            rsp_bus,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [bbe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [bbe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [bbe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import bbe_pkg::*;

   geom_type          geom;
   state_type         st_ff, st_in;

   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [IROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;
   pixel_type         px_ff, px_in;
   pixel_type         win_ff [WIN_TAPS];
   pixel_type         win_in [WIN_TAPS];
   sum_type           sum_ff, sum_in;

   pixel_type         upper_rd, middle_rd;
   logic              accept, skip, pixel_phase, produce;
   logic              mem_rd, mem_wr, sum_ld, div_go, slot_free;
   logic              last_row, last_col;
   logic [WIN_SIDE-1:0] row_on, col_on;
   logic [CNT_W-1:0]  tap_cnt;

   bbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .geom    (geom)
   );

   bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (in_col_ff),
      .wr_data (middle_rd),
      .rd_en   (mem_rd),
      .rd_addr (in_col_ff),
      .rd_data (upper_rd)
   );

   bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (in_col_ff),
      .wr_data (px_ff),
      .rd_en   (mem_rd),
      .rd_addr (in_col_ff),
      .rd_data (middle_rd)
   );

   bbe_mean u_mean (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .sum       (sum_ff),
      .slot_free (slot_free),
      .rsp_bus   (rsp_bus)
   );

   assign pixel_phase = in_row_ff < IROW_W'(geom.height);
   assign accept      = req_bus.valid && req_bus.ready;
   assign skip        = req_bus.flush && pixel_phase;
   assign produce     = (in_row_ff > IROW_W'(1)) ||
                        ((in_row_ff == IROW_W'(1)) && (in_col_ff != '0));

   // state machine: next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept && !skip) begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            st_in = produce ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            st_in = ST_DIV;
         end
         ST_DIV: begin
            if (slot_free) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_bus.ready = 1'b0;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      sum_ld        = 1'b0;
      div_go        = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            mem_rd        = req_bus.valid && !skip;
         end
         ST_READ: mem_wr = 1'b1;
         ST_SUM:  sum_ld = 1'b1;
         ST_DIV:  div_go = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // pixel latch, drain items carry zero
   always_comb begin
      px_in = px_ff;
      if (mem_rd) begin
         if (pixel_phase && !req_bus.flush) begin
            px_in = {req_bus.red_in, req_bus.green_in, req_bus.blue_in};
         end else begin
            px_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
   end

   // window shift and input position
   always_comb begin
      for (int k = 0; k < WIN_TAPS; k++) begin
         win_in[k] = win_ff[k];
      end
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (mem_wr) begin
         for (int k = 0; k < WIN_SIDE; k++) begin
            win_in[k*WIN_SIDE]     = win_ff[k*WIN_SIDE + 1];
            win_in[k*WIN_SIDE + 1] = win_ff[k*WIN_SIDE + 2];
         end
         win_in[2] = upper_rd;
         win_in[5] = middle_rd;
         win_in[8] = px_ff;
         if (in_row_ff > IROW_W'(geom.height)) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (WCNT_W'(in_col_ff) >= geom.width - WCNT_W'(1)) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
   end

   // neighbourhood sum and output position
   assign last_row = HCNT_W'(out_row_ff) >= geom.height - HCNT_W'(1);
   assign last_col = WCNT_W'(out_col_ff) >= geom.width - WCNT_W'(1);
   assign row_on   = {!last_row, 1'b1, out_row_ff != '0};
   assign col_on   = {!last_col, 1'b1, out_col_ff != '0};

   always_comb begin
      sum_in       = '0;
      tap_cnt      = '0;
      for (int k = 0; k < WIN_SIDE; k++) begin
         for (int p = 0; p < WIN_SIDE; p++) begin
            if (row_on[k] && col_on[p]) begin
               sum_in.red   = sum_in.red   +
                              SUM_W'(win_ff[k*WIN_SIDE + p][2*CHAN_W +: CHAN_W]);
               sum_in.green = sum_in.green +
                              SUM_W'(win_ff[k*WIN_SIDE + p][CHAN_W +: CHAN_W]);
               sum_in.blue  = sum_in.blue  +
                              SUM_W'(win_ff[k*WIN_SIDE + p][0 +: CHAN_W]);
               tap_cnt      = tap_cnt + CNT_W'(1);
            end
         end
      end
      sum_in.recip     = recip_of(tap_cnt);
      sum_in.frame_end = last_row && last_col;
   end

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (sum_ld) begin
         if (last_row && last_col) begin
            out_col_in = '0;
            out_row_in = '0;
         end else if (last_col) begin
            out_col_in = '0;
            out_row_in = out_row_ff + OROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ld) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         for (int k = 0; k < WIN_TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         for (int k = 0; k < WIN_TAPS; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

endmodule

`default_nettype wire

### sv/bbe_ram.sv
`default_nettype none

module bbe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/bbe_csr.sv
`default_nettype none

module bbe_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bbe_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [bbe_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [bbe_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready,
   output bbe_pkg::geom_type                      geom
);
   import bbe_pkg::*;

   logic [FW_W-1:0] frame_width_ff,  frame_width_in;
   logic [FH_W-1:0] frame_height_ff, frame_height_in;
   reg_index_type   sel;
   logic            wr_hit;

   assign sel    = reg_index_type'(paddr[REG_SEL_BIT]);
   assign wr_hit = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (wr_hit) begin
         unique case (sel)
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_W'(FW_RESET);
         frame_height_ff <= FH_W'(FH_RESET);
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      unique case (sel)
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp to 1..max
   always_comb begin
      if (frame_width_ff == '0) begin
         geom.width = WCNT_W'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         geom.width = WCNT_W'(MAX_WIDTH);
      end else begin
         geom.width = WCNT_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         geom.height = HCNT_W'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         geom.height = HCNT_W'(MAX_HEIGHT);
      end else begin
         geom.height = HCNT_W'(frame_height_ff);
      end
   end

endmodule

`default_nettype wire

### sv/bbe_mean.sv
`default_nettype none

module bbe_mean (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire bbe_pkg::sum_type sum,
   output logic                  slot_free,
   bbe_rsp_if.source             rsp_bus
);
   import bbe_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W;

   logic              valid_ff, valid_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic              frame_end_ff;
   logic [PROD_W-1:0] prod_r, prod_g, prod_b;

   // floor(sum / n) as sum * ceil(2^k / n) >> k
   assign prod_r = PROD_W'(sum.red)   * PROD_W'(sum.recip);
   assign prod_g = PROD_W'(sum.green) * PROD_W'(sum.recip);
   assign prod_b = PROD_W'(sum.blue)  * PROD_W'(sum.recip);

   assign slot_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
      if (start) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         red_ff       <= prod_r[RECIP_SHIFT +: CHAN_W];
         green_ff     <= prod_g[RECIP_SHIFT +: CHAN_W];
         blue_ff      <= prod_b[RECIP_SHIFT +: CHAN_W];
         frame_end_ff <= sum.frame_end;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.red_out   = red_ff;
   assign rsp_bus.green_out = green_ff;
   assign rsp_bus.blue_out  = blue_ff;
   assign rsp_bus.frame_end = frame_end_ff;

endmodule

`default_nettype wire

### test/tb_top.sv
`default_nettype none

module tb_top;
   import bbe_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 12;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              flush;
   } pixel_item_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_end;
   } mean_item_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bbe_req_if req_bus ();
   bbe_rsp_if rsp_bus ();

   box_blur_3x3_edge_average u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // stimulus and expected means
   pixel_item_type pending_pixels[$];
   mean_item_type  expected_means[$];

   // filter model state
   logic [PIX_W-1:0] upper_row_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_row_mem [MAX_WIDTH];
   logic [PIX_W-1:0] nbhd [WIN_TAPS];
   int unsigned      in_col, in_row, out_col, out_row;
   logic [FW_W-1:0]  cfg_width;
   logic [FH_W-1:0]  cfg_height;

   // bookkeeping
   int unsigned items_queued, items_accepted, results_seen, mismatch_count;
   int unsigned random_items, frames_queued, settings_used, ignored_flushes;
   int unsigned drain_pixels, frame_ends_seen, stall_count;

   // handshake pacing
   logic        req_taken, rsp_taken;
   bit          send_idle, rcv_idle;
   int unsigned send_wait, rcv_wait, hold_left, hold_asks, hold_seen;

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic predict_mean(input logic [CHAN_W-1:0] r, g, b, input logic fl);
      int unsigned      w, h, c, sr, sg, sb, n;
      int               k, p;
      logic [PIX_W-1:0] px, top, mid, v;
      bit               pix_phase, produce, last_row, last_col;
      mean_item_type    res;
      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      pix_phase = in_row < h;
      if (fl && pix_phase) begin
         ignored_flushes++;
         return;
      end
      if (!fl && !pix_phase) drain_pixels++;
      px = (!fl && pix_phase) ? {r, g, b} : '0;
      c = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
      top = upper_row_mem[c];
      mid = middle_row_mem[c];
      upper_row_mem[c] = mid;
      middle_row_mem[c] = px;
      for (k = 0; k < 3; k++) begin
         nbhd[k*3]   = nbhd[k*3+1];
         nbhd[k*3+1] = nbhd[k*3+2];
      end
      nbhd[2] = top;
      nbhd[5] = mid;
      nbhd[8] = px;
      produce = in_row > 1 || (in_row == 1 && in_col >= 1);
      if (in_row >= h + 1) begin
         in_row = 0;
         in_col = 0;
      end else if (in_col + 1 >= w) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
      if (!produce) return;
      sr = 0; sg = 0; sb = 0; n = 0;
      last_row = out_row + 1 >= h;
      last_col = out_col + 1 >= w;
      for (k = 0; k < 3; k++) begin
         if (k == 0 && out_row == 0) continue;
         if (k == 2 && last_row) continue;
         for (p = 0; p < 3; p++) begin
            if (p == 0 && out_col == 0) continue;
            if (p == 2 && last_col) continue;
            v = nbhd[k*3+p];
            sr += v[23:16];
            sg += v[15:8];
            sb += v[7:0];
            n++;
         end
      end
      res.red       = CHAN_W'(sr / n);
      res.green     = CHAN_W'(sg / n);
      res.blue      = CHAN_W'(sb / n);
      res.frame_end = last_row && last_col;
      if (res.frame_end) begin
         out_row = 0;
         out_col = 0;
      end else if (last_col) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      expected_means.push_back(res);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // input side: acceptance and prediction
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         items_accepted++;
         predict_mean(req_bus.red_in, req_bus.green_in, req_bus.blue_in, req_bus.flush);
      end
   end

   always @(negedge clock) begin : pixel_driver
      pixel_item_type it;
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (send_wait > 0) begin
            send_wait--;
            req_bus.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            it = pending_pixels.pop_front();
            req_bus.red_in   <= it.red;
            req_bus.green_in <= it.green;
            req_bus.blue_in  <= it.blue;
            req_bus.flush    <= it.flush;
            req_bus.valid    <= 1'b1;
            send_wait = send_idle ? $urandom_range(0, 11) : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side
   always @(posedge clock) begin : mean_monitor
      mean_item_type want;
      rsp_taken <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.frame_end) frame_ends_seen++;
         if (expected_means.size() == 0) begin
            $error("result transaction with no expected value: r=%0d g=%0d b=%0d end=%0d",
                   rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.frame_end);
            mismatch_count++;
         end else begin
            want = expected_means.pop_front();
            check_field("red_out", want.red, rsp_bus.red_out);
            check_field("green_out", want.green, rsp_bus.green_out);
            check_field("blue_out", want.blue, rsp_bus.blue_out);
            check_field("frame_end", want.frame_end, rsp_bus.frame_end);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (rsp_taken) rcv_wait = rcv_idle ? $urandom_range(0, 11) : 0;
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rcv_wait > 0) begin
         rcv_wait--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  stall_count, expected_means.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // csr access
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) << REG_SEL_BIT);
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_FRAME_WIDTH) cfg_width = val[FW_W-1:0];
      else cfg_height = val[FH_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input reg_index_type idx, input int unsigned want);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(int'(idx) << REG_SEL_BIT);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field(idx == REG_FRAME_WIDTH ? "prdata frame_width" : "prdata frame_height",
                  want, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (items_accepted != items_queued || expected_means.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned w_val, input int unsigned h_val);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, w_val);
      csr_write(REG_FRAME_HEIGHT, h_val);
      csr_check(REG_FRAME_WIDTH, w_val & ((1 << FW_W) - 1));
      csr_check(REG_FRAME_HEIGHT, h_val & ((1 << FH_W) - 1));
      settings_used++;
   endtask

   task automatic queue_item(input logic [CHAN_W-1:0] r, g, b, input logic fl);
      pixel_item_type it;
      it.red   = r;
      it.green = g;
      it.blue  = b;
      it.flush = fl;
      pending_pixels.push_back(it);
      items_queued++;
   endtask

   // raster pixels with stray flushes, then the drain with a few stray pixels
   task automatic queue_frame(input int unsigned w, input int unsigned h);
      int unsigned i;
      for (i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 15) == 0) queue_item(rand_chan(), rand_chan(), rand_chan(), 1'b1);
         queue_item(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      end
      for (i = 0; i <= w; i++)
         queue_item(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 7) != 0);
      random_items += w * h + w + 1;
      frames_queued++;
   endtask

   initial begin : stimulus
      int unsigned i, fw, fh, nf, w_val, h_val, phase;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.red_in = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      req_bus.flush    = 1'b0;
      rsp_bus.ready    = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      send_idle = 1'b1;
      rcv_idle  = 1'b1;
      for (i = 0; i < MAX_WIDTH; i++) begin
         upper_row_mem[i]  = '0;
         middle_row_mem[i] = '0;
      end
      for (i = 0; i < WIN_TAPS; i++) nbhd[i] = '0;
      cfg_width  = FW_W'(FW_RESET);
      cfg_height = FH_W'(FH_RESET);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero sizes clamp to a single pixel
      set_geometry(0, 0);
      queue_item(8'hFF, 8'h00, 8'hFF, 1'b1);
      queue_item(8'hFF, 8'h00, 8'hFF, 1'b0);
      queue_item(8'h00, 8'h00, 8'h00, 1'b1);
      queue_item(8'h5A, 8'hC3, 8'h3C, 1'b0);
      frames_queued++;

      // full 3x3 neighborhood at the center, near-max sums
      set_geometry(3, 3);
      for (i = 0; i < 9; i++) begin
         if (i == 5) queue_item(8'h00, 8'h00, 8'h00, 1'b1);
         if (i == 8) queue_item(8'h00, 8'h80, 8'h01, 1'b0);
         else queue_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
      end
      queue_item(8'h00, 8'h00, 8'h00, 1'b1);
      queue_item(8'hA5, 8'h5A, 8'hFF, 1'b0);
      queue_item(8'h00, 8'h00, 8'h00, 1'b1);
      queue_item(8'h00, 8'h00, 8'h00, 1'b1);
      frames_queued++;

      set_geometry(2, 2);
      queue_item(8'h00, 8'h00, 8'h00, 1'b0);
      queue_item(8'h01, 8'h02, 8'h03, 1'b0);
      queue_item(8'hFE, 8'hFD, 8'hFC, 1'b0);
      queue_item(8'h80, 8'h7F, 8'h81, 1'b0);
      for (i = 0; i < 3; i++) queue_item(8'h00, 8'h00, 8'h00, 1'b1);
      frames_queued++;

      // random frame sizes and contents
      random_items = 0;
      phase = 0;
      while (random_items < 720) begin
         fw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         fh = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 8);
         w_val = ($urandom_range(0, 9) == 0) ? 0 : fw;
         h_val = ($urandom_range(0, 9) == 0) ? 0 : fh;
         set_geometry(w_val, h_val);
         send_idle = $urandom_range(0, 3) != 0;
         rcv_idle  = $urandom_range(0, 3) != 0;
         nf = $urandom_range(1, 3);
         for (i = 0; i < nf; i++)
            queue_frame(clamp_dim(w_val, MAX_WIDTH), clamp_dim(h_val, MAX_HEIGHT));
         if (phase == 3) hold_asks++;
         phase++;
      end

      // register readback above the size limits, no frame at these sizes
      set_geometry(2047, 8191);

      // result side held off while the sender keeps offering, input backs up
      set_geometry(12, 4);
      send_idle = 1'b0;
      rcv_idle  = 1'b1;
      queue_frame(12, 4);
      hold_asks++;

      wait_idle();
      $display("run covered %0d frames over %0d size settings, %0d pixel-side transactions",
               frames_queued, settings_used, items_accepted);
      $display("%0d means checked, %0d frame ends, %0d ignored flushes, %0d pixels in drain",
               results_seen, frame_ends_seen, ignored_flushes, drain_pixels);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
sv/bbe_pkg.sv
sv/bbe_ifs.sv
sv/bbe_ram.sv
sv/bbe_csr.sv
sv/bbe_mean.sv
sv/box_blur_3x3_edge_average.sv
test/tb_top.sv
